/* hdl/xtrs_pkg.sv */
// Shared types and constants for the xor trie range-sum block.
package xtrs_pkg;
  localparam int NODE_COUNT_DEF = 4096;
  localparam int KEY_BITS_DEF = 31;
  localparam logic [29:0] PRIME = 30'd1000000007;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] key;
    logic [29:0] weight;
    logic [30:0] limit;
  } req_t;

  typedef struct packed {
    logic [29:0] total;
    logic        pool_full;
  } rsp_t;

  // a, b < PRIME
  function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      add_mod = (s >= {1'b0, PRIME}) ? 30'(s - {1'b0, PRIME}) : s[29:0];
    end
  endfunction

  // w < 2^30 < 2*PRIME, so one subtract reduces it
  function automatic logic [29:0] red_mod(input logic [29:0] w);
    red_mod = (w >= PRIME) ? 30'(w - PRIME) : w;
  endfunction
endpackage

/* hdl/xtrs_if.sv */
// Valid/ready channel carrying one payload.
interface xtrs_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/xtrs_front.sv */
// Front end: accept requests, reduce weight, push into a two-entry queue.
module xtrs_front (
  input  logic clk,
  input  logic rst,
  xtrs_if.sink in,
  output logic q_valid,
  output xtrs_pkg::req_t q_data,
  input  logic q_pop
);
  xtrs_pkg::req_t buf0, buf1;
  logic [1:0] count;
  logic push;

  assign in.ready = (count != 2'd2);
  assign push = in.valid && in.ready;
  assign q_valid = (count != 2'd0);
  assign q_data = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= 2'(count + {1'b0, push} - {1'b0, q_pop});
    end
  end

  always_ff @(posedge clk) begin
    xtrs_pkg::req_t r;
    r = in.data;
    r.weight = xtrs_pkg::red_mod(in.data.weight);
    if (q_pop) begin
      buf0 <= buf1;
      if (push && count == 2'd1) buf0 <= r;
      if (push && count == 2'd2) buf1 <= r;
    end else if (push) begin
      if (count == 2'd0) buf0 <= r;
      else buf1 <= r;
    end
  end
endmodule

/* hdl/xtrs_back.sv */
// Back end: walk the trie one level at a time through node memory.
module xtrs_back #(
  parameter int NODE_COUNT = xtrs_pkg::NODE_COUNT_DEF,
  parameter int KEY_BITS = xtrs_pkg::KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  xtrs_pkg::req_t q_data,
  output logic q_pop,
  xtrs_if.source out
);
  localparam int AW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int BW = $clog2(KEY_BITS + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_SCAN = 3'd2,
    S_INS = 3'd3, S_QRY = 3'd4, S_OUT = 3'd5;

  logic [AW-1:0] kid0 [NODE_COUNT];
  logic [AW-1:0] kid1 [NODE_COUNT];
  logic [29:0]   nsum [NODE_COUNT];

  logic [2:0]   state;
  xtrs_pkg::req_t cur;
  logic [AW-1:0] u;
  logic [BW-1:0] b;
  logic [CW-1:0] used;
  logic          root_empty;
  logic          scan;
  logic          fresh;
  logic          live;
  logic          side_on;
  logic [29:0]   acc;
  logic [AW-1:0] rk0, rk1;
  logic [29:0]   rs, rss;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] side_addr;
  xtrs_pkg::rsp_t res;

  // root reads as empty after reset or clear; a fresh node reads as empty
  logic          blank;
  logic [AW-1:0] k0, k1;
  logic [29:0]   s0;
  logic [BW-1:0] bi;
  logic          kb, lb;
  logic [AW-1:0] kid, nxt;
  logic [29:0]   acc_now;
  logic          we;
  logic [AW-1:0] wk0, wk1;
  logic [29:0]   ws;

  always_comb begin
    blank = fresh || (root_empty && u == '0);
    k0 = blank ? '0 : rk0;
    k1 = blank ? '0 : rk1;
    s0 = blank ? '0 : rs;
    bi = BW'(b - 1'b1);
    kb = cur.key[bi];
    lb = cur.limit[bi];
    kid = kb ? k1 : k0;
    nxt = (lb ? ~kb : kb) ? k1 : k0;
    acc_now = side_on ? xtrs_pkg::add_mod(acc, rss) : acc;
    we = !rst && (state == S_INS);
    ws = xtrs_pkg::add_mod(s0, cur.weight);
    wk0 = (b != '0 && kid == '0 && !kb) ? AW'(used) : k0;
    wk1 = (b != '0 && kid == '0 && kb) ? AW'(used) : k1;
  end

  assign q_pop = (state == S_IDLE) && q_valid;
  assign out.valid = (state == S_OUT);
  assign out.data = res;

  always_ff @(posedge clk) begin
    rk0 <= kid0[rd_addr];
    rk1 <= kid1[rd_addr];
    rs  <= nsum[rd_addr];
    rss <= nsum[side_addr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      kid0[u] <= wk0;
      kid1[u] <= wk1;
      nsum[u] <= ws;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= CW'(1);
      root_empty <= 1'b1;
      rd_addr <= '0;
      side_addr <= '0;
      u <= '0;
      fresh <= 1'b0;
      side_on <= 1'b0;
      res <= '0;
    end else begin
      case (state)
        S_IDLE: if (q_valid) begin
          cur <= q_data;
          u <= '0;
          rd_addr <= '0;
          b <= BW'(KEY_BITS);
          acc <= '0;
          live <= 1'b1;
          side_on <= 1'b0;
          fresh <= 1'b0;
          scan <= 1'b1;
          res <= '0;
          case (q_data.op)
            xtrs_pkg::OP_INSERT, xtrs_pkg::OP_QUERY: state <= S_RD;
            xtrs_pkg::OP_CLEAR: begin
              root_empty <= 1'b1;
              used <= CW'(1);
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_RD: begin
          // wait for the registered read
          if (cur.op == xtrs_pkg::OP_QUERY) state <= S_QRY;
          else if (scan) state <= S_SCAN;
          else state <= S_INS;
        end
        S_SCAN: begin
          // find depth of first missing child, then restart from the root (or end with pool_full)
          if (b == '0 || kid == '0) begin
            scan <= 1'b0;
            b <= BW'(KEY_BITS);
            u <= '0;
            rd_addr <= '0;
            state <= S_RD;
            if (b != '0 && int'(b) > NODE_COUNT - int'(used)) begin
              res.pool_full <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            u <= kid;
            rd_addr <= kid;
            b <= BW'(b - 1'b1);
            state <= S_RD;
          end
        end
        S_INS: begin
          // node u gets the weight; a missing child is taken from the pool
          if (u == '0) root_empty <= 1'b0;
          if (b == '0) begin
            state <= S_OUT;
          end else begin
            if (kid == '0) begin
              u <= AW'(used);
              rd_addr <= AW'(used);
              used <= CW'(used + 1'b1);
              fresh <= 1'b1;
            end else begin
              u <= kid;
              rd_addr <= kid;
              fresh <= 1'b0;
            end
            b <= BW'(b - 1'b1);
            state <= S_RD;
          end
        end
        S_QRY: begin
          // the same-side subtree sum arrives one level later on the side port
          if (!live) begin
            res.total <= acc_now;
            state <= S_OUT;
          end else if (b == '0) begin
            res.total <= xtrs_pkg::add_mod(acc_now, s0);
            state <= S_OUT;
          end else begin
            acc <= acc_now;
            side_on <= lb && (kid != '0);
            side_addr <= kid;
            if (nxt == '0) begin
              live <= 1'b0;
            end else begin
              u <= nxt;
              rd_addr <= nxt;
              b <= BW'(b - 1'b1);
            end
            state <= S_RD;
          end
        end
        S_OUT: if (out.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used >= CW'(1) && used <= CW'(NODE_COUNT)) else $error("node count out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE) else $error("pop without start");
  a_clear_root: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_data.op == xtrs_pkg::OP_CLEAR) |=> root_empty && used == CW'(1))
    else $error("clear failed");
`endif
endmodule

/* hdl/xor_trie_weighted_range_sum.sv */
// Top level of the xor trie range-sum block.
// Channel req carries op, key, weight, limit; channel rsp carries total and
// pool_full, one response per request, in order. Both use valid/ready.
// The front end reduces the weight and queues up to two requests; the back
// end takes one request at a time and walks the trie one level at a time
// (registered node-memory read, then scan, update or compare).
// A query ends early when the walk leaves the trie; an insert makes a scan
// pass to count missing nodes, then an update pass (a dropped insert ends
// after the scan); a clear or unused op goes straight to the response.
// The next request starts from idle once the response is taken.
// Reset empties the trie at once (root flag, node count one); no sweep.
// When rsp is stalled the response holds and the back end waits; the
// front queue keeps taking requests until it is full.
module xor_trie_weighted_range_sum #(
  parameter int NODE_COUNT = xtrs_pkg::NODE_COUNT_DEF,
  parameter int KEY_BITS = xtrs_pkg::KEY_BITS_DEF
) (
  input logic clk,
  input logic rst,
  xtrs_if.sink req,
  xtrs_if.source rsp
);
  logic q_valid, q_pop;
  xtrs_pkg::req_t q_data;

  xtrs_front u_front (.clk(clk), .rst(rst), .in(req), .q_valid(q_valid),
    .q_data(q_data), .q_pop(q_pop));

  xtrs_back #(.NODE_COUNT(NODE_COUNT), .KEY_BITS(KEY_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out(rsp));
endmodule
